FILE: hdl/cpvc_pkg.sv
// Shared types, operation codes and helper functions for the cascaded position controller.
package cpvc_pkg;

    localparam int FRAC_BITS = 16;

    typedef struct packed {
        logic [16:0] filter_alpha;
        logic [30:0] pos_gain_xy;
        logic [30:0] pos_gain_z;
        logic [30:0] vel_gain_xy;
        logic [30:0] vel_gain_z;
        logic [30:0] descent_limit;
        logic [30:0] ascent_limit;
        logic [30:0] lateral_accel_limit;
    } cfg_t;

    typedef logic [3:0] op_t;

    localparam op_t OP_NOP  = 4'd0;
    localparam op_t OP_FA   = 4'd1;
    localparam op_t OP_FB   = 4'd2;
    localparam op_t OP_PV   = 4'd3;
    localparam op_t OP_VE   = 4'd4;
    localparam op_t OP_AC   = 4'd5;
    localparam op_t OP_SQ   = 4'd6;
    localparam op_t OP_LL   = 4'd7;
    localparam op_t OP_SQRT = 4'd8;
    localparam op_t OP_MX   = 4'd9;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic       load;
        op_t        op;
        logic [1:0] axis;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic over;
        logic sqrt_done;
        logic div_done;
    } stat_t;

    function automatic logic signed [65:0] sx66(input logic signed [31:0] v);
        sx66 = {{34{v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            sat66 = 32'sh7fff_ffff;
        else if (v < -66'sd2147483648)
            sat66 = 32'sh8000_0000;
        else
            sat66 = v[31:0];
    endfunction

endpackage

FILE: hdl/cpvc_isqrt.sv
// Bit-serial integer square root of a 64-bit value, two radicand bits per cycle.
module cpvc_isqrt
    import cpvc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] xs_reg, xs_next;
    logic [34:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [34:0] rem_shift;
    logic [34:0] trial;

    always_comb
    begin
        rem_shift = {rem_reg[32:0], xs_reg[63:62]};
        trial     = {1'b0, root_reg, 2'b01};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        xs_next   = xs_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            xs_next   = radicand;
            rem_next  = 35'd0;
            root_next = 32'd0;
        end
        else if (busy_reg)
        begin
            xs_next = {xs_reg[61:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift;
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xs_reg   <= xs_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: hdl/cpvc_div.sv
// Restoring divider, one quotient bit per cycle, for a quotient known to fit 32 bits.
module cpvc_div
    import cpvc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [61:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dd_reg, dd_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] n_reg, n_next;
    logic [32:0] trial;
    logic [32:0] diff;

    always_comb
    begin
        trial     = {rem_reg, dd_reg[31]};
        diff      = trial - {1'b0, n_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dd_next   = dd_reg;
        q_next    = q_reg;
        n_next    = n_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            rem_next  = {2'b00, dividend[61:32]};
            dd_next   = dividend[31:0];
            q_next    = 32'd0;
            n_next    = divisor;
        end
        else if (busy_reg)
        begin
            dd_next = {dd_reg[30:0], 1'b0};
            if (trial >= {1'b0, n_reg})
            begin
                rem_next = diff[31:0];
                q_next   = {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                q_next   = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dd_reg  <= dd_next;
        q_reg   <= q_next;
        n_reg   <= n_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: hdl/cpvc_datapath.sv
// Datapath: shared multiplier, filter, P stages, tilt limiting and result registers.
module cpvc_datapath
    import cpvc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  cmd_t         cmd,
    output stat_t        stat,
    input  logic [287:0] in_data,
    input  logic         in_flag,
    output logic [95:0]  out_data,
    output logic         out_flag
);

    localparam logic signed [32:0] ONE = 33'sd1 <<< FRAC_BITS;

    logic signed [31:0] vel_reg [3];
    logic signed [31:0] perr_reg [3];
    logic signed [31:0] filt_reg [3];
    logic signed [31:0] vc_reg [3];
    logic signed [31:0] acc_reg [3];
    logic signed [65:0] mix_reg;
    logic signed [65:0] prod_reg;
    logic [63:0]        sum_reg;
    logic               over_reg;
    logic               tilt_reg;
    logic               div_axis_reg;
    op_t                op_d_reg;
    logic [1:0]         axis_d_reg;
    logic [95:0]        out_data_reg;
    logic               out_flag_reg;

    logic signed [32:0] alpha_c;
    logic signed [32:0] opa;
    logic signed [32:0] opb;
    logic signed [32:0] acc_ext;
    logic signed [31:0] prod_q;
    logic signed [31:0] vz_clamped;
    logic signed [32:0] up_lim;
    logic signed [32:0] down_lim;
    logic signed [31:0] diff_sat [3];
    logic [31:0]        root;
    logic [31:0]        quotient;
    logic [31:0]        q_lim;
    logic               sqrt_done;
    logic               div_done;
    logic               sqrt_start;
    logic               div_start;

    always_comb
    begin
        alpha_c = ($signed({16'd0, cfg.filter_alpha}) > ONE) ? ONE
                                                             : $signed({16'd0, cfg.filter_alpha});
        acc_ext = {acc_reg[cmd.axis][31], acc_reg[cmd.axis]};
        opa = 33'sd0;
        opb = 33'sd0;
        unique case (cmd.op)
            OP_FA:
            begin
                opa = alpha_c;
                opb = {vel_reg[cmd.axis][31], vel_reg[cmd.axis]};
            end
            OP_FB:
            begin
                opa = ONE - alpha_c;
                opb = {filt_reg[cmd.axis][31], filt_reg[cmd.axis]};
            end
            OP_PV:
            begin
                opa = (cmd.axis == AXIS_Z) ? {2'b00, cfg.pos_gain_z} : {2'b00, cfg.pos_gain_xy};
                opb = {perr_reg[cmd.axis][31], perr_reg[cmd.axis]};
            end
            OP_AC:
            begin
                opa = (cmd.axis == AXIS_Z) ? {2'b00, cfg.vel_gain_z} : {2'b00, cfg.vel_gain_xy};
                opb = {vc_reg[cmd.axis][31], vc_reg[cmd.axis]};
            end
            OP_SQ:
            begin
                opa = acc_ext;
                opb = acc_ext;
            end
            OP_LL:
            begin
                opa = {2'b00, cfg.lateral_accel_limit};
                opb = {2'b00, cfg.lateral_accel_limit};
            end
            OP_MX:
            begin
                opa = acc_ext[32] ? -acc_ext : acc_ext;
                opb = {2'b00, cfg.lateral_accel_limit};
            end
            default:
            begin
                opa = 33'sd0;
                opb = 33'sd0;
            end
        endcase
    end

    always_comb
    begin
        prod_q   = sat66(prod_reg >>> FRAC_BITS);
        up_lim   = $signed({2'b00, cfg.ascent_limit});
        down_lim = -$signed({2'b00, cfg.descent_limit});
        vz_clamped = prod_q;
        if ($signed({prod_q[31], prod_q}) > up_lim)
            vz_clamped = up_lim[31:0];
        if ($signed({vz_clamped[31], vz_clamped}) < down_lim)
            vz_clamped = down_lim[31:0];
        for (int i = 0; i < 3; i++)
            diff_sat[i] = sat66(sx66(vc_reg[i]) - sx66(filt_reg[i]));
        q_lim      = (quotient > 32'h8000_0000) ? 32'h8000_0000 : quotient;
        sqrt_start = (op_d_reg == OP_SQRT);
        div_start  = (op_d_reg == OP_MX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_d_reg   <= OP_NOP;
            axis_d_reg <= AXIS_X;
            for (int i = 0; i < 3; i++)
                filt_reg[i] <= 32'sd0;
        end
        else
        begin
            op_d_reg   <= cmd.op;
            axis_d_reg <= cmd.axis;
            if (op_d_reg == OP_FB)
                filt_reg[axis_d_reg] <= sat66((mix_reg + prod_reg) >>> FRAC_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
        if (cmd.load)
        begin
            tilt_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                vel_reg[i]  <= in_data[96 + 32*i +: 32];
                perr_reg[i] <= in_flag ? sat66(sx66(in_data[192 + 32*i +: 32])
                                               - sx66(in_data[32*i +: 32])) : 32'sd0;
            end
        end
        unique case (op_d_reg)
            OP_FA: mix_reg <= prod_reg;
            OP_PV: vc_reg[axis_d_reg] <= (axis_d_reg == AXIS_Z) ? vz_clamped : prod_q;
            OP_VE: vc_reg[axis_d_reg] <= diff_sat[axis_d_reg];
            OP_AC: acc_reg[axis_d_reg] <= prod_q;
            OP_SQ: sum_reg <= (axis_d_reg == AXIS_X) ? prod_reg[63:0]
                                                     : sum_reg + prod_reg[63:0];
            OP_LL: over_reg <= (sum_reg > prod_reg[63:0]);
            OP_SQRT: tilt_reg <= 1'b1;
            OP_MX: div_axis_reg <= axis_d_reg[0];
            default: ;
        endcase
        if (div_done)
        begin
            if (acc_reg[{1'b0, div_axis_reg}][31])
                acc_reg[{1'b0, div_axis_reg}] <= -q_lim;
            else
                acc_reg[{1'b0, div_axis_reg}] <= q_lim[31] ? 32'h7fff_ffff : q_lim;
        end
        if (cmd.emit)
        begin
            out_data_reg <= {acc_reg[2], acc_reg[1], acc_reg[0]};
            out_flag_reg <= tilt_reg;
        end
    end

    cpvc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    cpvc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg[61:0]),
        .divisor  (root),
        .done     (div_done),
        .quotient (quotient)
    );

    assign stat.over      = over_reg;
    assign stat.sqrt_done = sqrt_done;
    assign stat.div_done  = div_done;
    assign out_data       = out_data_reg;
    assign out_flag       = out_flag_reg;

endmodule

FILE: hdl/cpvc_ctrl.sv
// Controller: sequences the datapath operations and runs the stream handshakes.
module cpvc_ctrl
    import cpvc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_SQW   = 3'd4;
    localparam logic [2:0] S_DIVW  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic [4:0] LAST_STEP = 5'd17;

    logic [2:0] state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic       dax_reg, dax_next;
    logic       out_valid_reg, out_valid_next;
    op_t        prog_op;
    logic [1:0] prog_axis;

    always_comb
    begin
        prog_op   = OP_NOP;
        prog_axis = AXIS_X;
        if (step_reg < 5'd6)
        begin
            prog_op   = step_reg[0] ? OP_FB : OP_FA;
            prog_axis = step_reg[2:1];
        end
        else if (step_reg < 5'd9)
        begin
            prog_op   = OP_PV;
            prog_axis = 2'(step_reg - 5'd6);
        end
        else if (step_reg < 5'd12)
        begin
            prog_op   = OP_VE;
            prog_axis = 2'(step_reg - 5'd9);
        end
        else if (step_reg < 5'd15)
        begin
            prog_op   = OP_AC;
            prog_axis = 2'(step_reg - 5'd12);
        end
        else if (step_reg < LAST_STEP)
        begin
            prog_op   = OP_SQ;
            prog_axis = 2'(step_reg - 5'd15);
        end
        else
        begin
            prog_op   = OP_LL;
            prog_axis = AXIS_X;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        dax_next       = dax_reg;
        out_valid_next = out_valid_reg;
        cmd            = '{load: 1'b0, op: OP_NOP, axis: AXIS_X, emit: 1'b0};
        if (out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = 5'd0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.op    = prog_op;
                cmd.axis  = prog_axis;
                step_next = step_reg + 5'd1;
                if (step_reg == LAST_STEP)
                    state_next = S_WAIT;
            end
            S_WAIT:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.over)
                begin
                    cmd.op     = OP_SQRT;
                    state_next = S_SQW;
                end
                else
                    state_next = S_DONE;
            end
            S_SQW:
            begin
                if (stat.sqrt_done)
                begin
                    cmd.op     = OP_MX;
                    cmd.axis   = AXIS_X;
                    dax_next   = 1'b0;
                    state_next = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (stat.div_done)
                begin
                    if (!dax_reg)
                    begin
                        cmd.op   = OP_MX;
                        cmd.axis = AXIS_Y;
                        dax_next = 1'b1;
                    end
                    else
                        state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 5'd0;
            dax_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            dax_reg       <= dax_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_RUN && step_reg == 5'd0))
        else $error("accepted word did not start the sequence");

    a_sqrt_needs_over: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQW) |-> stat.over)
        else $error("square root running without tilt limit exceeded");

    a_emit_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result presented outside the completion state");

endmodule

FILE: hdl/cascaded_position_velocity_controller.sv
// Top level: cascaded position and velocity controller with tilt limiting.
//
// Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser: nine Q16.16 values
// (measured position, measured velocity, goal position) and the goal valid flag.
// Each accepted word yields exactly one result word on m_tvalid/m_tready/m_tdata,
// carrying three Q16.16 accelerations, with the tilt limit flag on m_tuser.
// The user must write gains and limits through the APB-style port only while the
// block is idle; the block itself does not enforce this. One shared multiplier
// runs eighteen operations per word. When the horizontal acceleration exceeds
// the lateral limit, a bit-serial square root and two bit-serial divisions run
// before the result is registered. A new word is taken once the previous one has
// reached the output register, even if that result has not yet been collected; a
// stalled receiver holds the result and the following word waits in its final
// stage until the register frees.
// Reset clears the filtered velocity to zero and loads the default register values.
module cascaded_position_velocity_controller
    import cpvc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // meas_pos_x, meas_pos_y, meas_pos_z, meas_vel_x, meas_vel_y, meas_vel_z,
    // goal_x, goal_y, goal_z
    input  logic [287:0] s_tdata,
    // goal_valid
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // accel_x, accel_y, accel_z
    output logic [95:0]  m_tdata,
    // tilt_limited
    output logic         m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [2:0] REG_ALPHA  = 3'd0;
    localparam logic [2:0] REG_PGXY   = 3'd1;
    localparam logic [2:0] REG_PGZ    = 3'd2;
    localparam logic [2:0] REG_VGXY   = 3'd3;
    localparam logic [2:0] REG_VGZ    = 3'd4;
    localparam logic [2:0] REG_DESC   = 3'd5;
    localparam logic [2:0] REG_ASC    = 3'd6;
    localparam logic [2:0] REG_LATLIM = 3'd7;

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;
    logic  wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_alpha        <= 17'd65536;
            cfg_reg.pos_gain_xy         <= 31'd65536;
            cfg_reg.pos_gain_z          <= 31'd65536;
            cfg_reg.vel_gain_xy         <= 31'd65536;
            cfg_reg.vel_gain_z          <= 31'd65536;
            cfg_reg.descent_limit       <= 31'd65536;
            cfg_reg.ascent_limit        <= 31'd65536;
            cfg_reg.lateral_accel_limit <= 31'd655360;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ALPHA:  cfg_reg.filter_alpha        <= pwdata[16:0];
                REG_PGXY:   cfg_reg.pos_gain_xy         <= pwdata[30:0];
                REG_PGZ:    cfg_reg.pos_gain_z          <= pwdata[30:0];
                REG_VGXY:   cfg_reg.vel_gain_xy         <= pwdata[30:0];
                REG_VGZ:    cfg_reg.vel_gain_z          <= pwdata[30:0];
                REG_DESC:   cfg_reg.descent_limit       <= pwdata[30:0];
                REG_ASC:    cfg_reg.ascent_limit        <= pwdata[30:0];
                REG_LATLIM: cfg_reg.lateral_accel_limit <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ALPHA:  prdata = {15'd0, cfg_reg.filter_alpha};
            REG_PGXY:   prdata = {1'b0, cfg_reg.pos_gain_xy};
            REG_PGZ:    prdata = {1'b0, cfg_reg.pos_gain_z};
            REG_VGXY:   prdata = {1'b0, cfg_reg.vel_gain_xy};
            REG_VGZ:    prdata = {1'b0, cfg_reg.vel_gain_z};
            REG_DESC:   prdata = {1'b0, cfg_reg.descent_limit};
            REG_ASC:    prdata = {1'b0, cfg_reg.ascent_limit};
            REG_LATLIM: prdata = {1'b0, cfg_reg.lateral_accel_limit};
            default:    prdata = 32'd0;
        endcase
    end

    cpvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cpvc_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  (s_tdata),
        .in_flag  (s_tuser),
        .out_data (m_tdata),
        .out_flag (m_tuser)
    );

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the cascaded position and velocity controller.
module tb_top;
    import cpvc_pkg::*;

    localparam int FRAC = 16;
    localparam longint ONE_Q = 64'sd1 << FRAC;
    localparam int WDOG_LIMIT = 20000;
    localparam int N_RANDOM = 1430;

    localparam logic [4:0] ADDR_ALPHA   = 5'd0;
    localparam logic [4:0] ADDR_PGXY    = 5'd4;
    localparam logic [4:0] ADDR_PGZ     = 5'd8;
    localparam logic [4:0] ADDR_VGXY    = 5'd12;
    localparam logic [4:0] ADDR_VGZ     = 5'd16;
    localparam logic [4:0] ADDR_DESCENT = 5'd20;
    localparam logic [4:0] ADDR_ASCENT  = 5'd24;
    localparam logic [4:0] ADDR_LATERAL = 5'd28;

    typedef struct packed {
        logic        goal_valid;
        logic [31:0] goal_z;
        logic [31:0] goal_y;
        logic [31:0] goal_x;
        logic [31:0] vel_z;
        logic [31:0] vel_y;
        logic [31:0] vel_x;
        logic [31:0] pos_z;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } odom_t;

    typedef struct packed {
        logic        tilt;
        logic [31:0] acc_z;
        logic [31:0] acc_y;
        logic [31:0] acc_x;
    } accel_t;

    typedef struct {
        odom_t  word;
        logic   has_fixed;
        accel_t fixed;
    } vector_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [287:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [95:0] m_tdata;
    logic m_tuser;
    logic psel;
    logic penable;
    logic pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    longint gain_reg [8];
    longint filt_vel [3];
    accel_t accel_expected [$];
    int errors;
    int words_sent;
    int words_checked;
    int tilt_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off;
    int idle_cycles;
    vector_t vectors [$];

    cascaded_position_velocity_controller u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qscale(input longint g, input longint v);
        return sat32((g * v) >>> FRAC);
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint shrink_axis(input longint a, input logic [63:0] lim,
                                           input logic [63:0] n);
        logic [63:0] mag;
        logic [63:0] q;
        longint r;
        mag = (a < 0) ? -a : a;
        q = (mag * lim) / n;
        r = (q > 64'd2147483648) ? 64'sd2147483648 : longint'(q);
        return sat32(a < 0 ? -r : r);
    endfunction

    function automatic void reset_controller_model();
        gain_reg = '{65536, 65536, 65536, 65536, 65536, 65536, 65536, 655360};
        filt_vel = '{0, 0, 0};
    endfunction

    function automatic accel_t control_law(input odom_t w);
        longint alpha;
        longint pos [3];
        longint vel [3];
        longint goal [3];
        longint perr [3];
        longint vcmd [3];
        longint acc [3];
        logic [63:0] lim;
        logic [63:0] sum;
        logic [63:0] n;
        accel_t r;
        pos = '{longint'($signed(w.pos_x)), longint'($signed(w.pos_y)),
                longint'($signed(w.pos_z))};
        vel = '{longint'($signed(w.vel_x)), longint'($signed(w.vel_y)),
                longint'($signed(w.vel_z))};
        goal = '{longint'($signed(w.goal_x)), longint'($signed(w.goal_y)),
                 longint'($signed(w.goal_z))};
        alpha = (gain_reg[0] > ONE_Q) ? ONE_Q : gain_reg[0];
        r.tilt = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            filt_vel[i] = sat32((alpha * vel[i] + (ONE_Q - alpha) * filt_vel[i]) >>> FRAC);
            perr[i] = w.goal_valid ? sat32(goal[i] - pos[i]) : 0;
        end
        vcmd[0] = qscale(gain_reg[1], perr[0]);
        vcmd[1] = qscale(gain_reg[1], perr[1]);
        vcmd[2] = qscale(gain_reg[2], perr[2]);
        if (vcmd[2] > gain_reg[6])
            vcmd[2] = gain_reg[6];
        if (vcmd[2] < -gain_reg[5])
            vcmd[2] = -gain_reg[5];
        for (int i = 0; i < 3; i++)
            acc[i] = qscale(i < 2 ? gain_reg[3] : gain_reg[4], sat32(vcmd[i] - filt_vel[i]));
        lim = gain_reg[7];
        sum = acc[0] * acc[0] + acc[1] * acc[1];
        if (sum > lim * lim)
        begin
            n = root64(sum);
            if (n == 0)
                n = 1;
            acc[0] = shrink_axis(acc[0], lim, n);
            acc[1] = shrink_axis(acc[1], lim, n);
            r.tilt = 1'b1;
        end
        r.acc_x = acc[0][31:0];
        r.acc_y = acc[1][31:0];
        r.acc_z = acc[2][31:0];
        return r;
    endfunction

    task automatic write_reg(input logic [4:0] addr, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        gain_reg[addr >> 2] = (addr == ADDR_ALPHA) ? longint'(value[16:0])
                                                   : longint'(value[30:0]);
    endtask

    task automatic drain();
        while (accel_expected.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic send_word(input odom_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w[287:0];
        s_tuser <= w.goal_valid;
        accel_expected.push_back(control_law(w));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            3: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic odom_t random_odom();
        odom_t w;
        w.pos_x = pick_value();
        w.pos_y = pick_value();
        w.pos_z = pick_value();
        w.vel_x = pick_value();
        w.vel_y = pick_value();
        w.vel_z = pick_value();
        w.goal_x = pick_value();
        w.goal_y = pick_value();
        w.goal_z = pick_value();
        w.goal_valid = ($urandom_range(9) != 0);
        return w;
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(4))
            0: return 32'h7fff_ffff;
            1: return 32'd0;
            2: return $urandom_range(0, 32'h0004_0000);
            default: return {1'b0, 31'($urandom)};
        endcase
    endfunction

    task automatic random_config();
        write_reg(ADDR_ALPHA, $urandom_range(0, 32'h1ffff));
        write_reg(ADDR_PGXY, pick_gain());
        write_reg(ADDR_PGZ, pick_gain());
        write_reg(ADDR_VGXY, pick_gain());
        write_reg(ADDR_VGZ, pick_gain());
        write_reg(ADDR_DESCENT, pick_gain());
        write_reg(ADDR_ASCENT, pick_gain());
        write_reg(ADDR_LATERAL, pick_gain());
    endtask

    function automatic odom_t make_odom(input logic [31:0] p, input logic [31:0] v,
                                        input logic [31:0] g, input logic ok);
        odom_t w;
        w.pos_x = p;
        w.pos_y = ~p;
        w.pos_z = p;
        w.vel_x = v;
        w.vel_y = v;
        w.vel_z = ~v;
        w.goal_x = g;
        w.goal_y = g;
        w.goal_z = ~g;
        w.goal_valid = ok;
        return w;
    endfunction

    task automatic add_vector(input odom_t w, input logic fixed_ok, input accel_t f);
        vector_t e;
        e.word = w;
        e.has_fixed = fixed_ok;
        e.fixed = f;
        vectors.push_back(e);
    endtask

    // Receiver: random stalls, plus one long hold-off while words keep arriving.
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        accel_t got;
        accel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata};
            if (accel_expected.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
            end
            else
            begin
                want = accel_expected.pop_front();
                words_checked++;
                tilt_count += got.tilt;
                if (got.acc_x !== want.acc_x)
                    $display("%0t: accel_x expected %h actual %h", $time, want.acc_x, got.acc_x);
                if (got.acc_y !== want.acc_y)
                    $display("%0t: accel_y expected %h actual %h", $time, want.acc_y, got.acc_y);
                if (got.acc_z !== want.acc_z)
                    $display("%0t: accel_z expected %h actual %h", $time, want.acc_z, got.acc_z);
                if (got.tilt !== want.tilt)
                    $display("%0t: tilt_limited expected %b actual %b", $time, want.tilt, got.tilt);
                if (got !== want)
                    errors++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        accel_t none;
        none = '0;
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        tilt_count = 0;
        hold_off = 0;
        idle_cycles = 0;
        send_idle_pct = 24;
        recv_idle_pct = 80;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        reset_controller_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // After reset, near-zero inputs give a one-LSB acceleration on a single axis.
        add_vector(make_odom(32'd0, 32'd0, 32'd0, 1'b0), 1'b1,
                   {1'b0, 32'd1, 32'd0, 32'd0});
        add_vector(make_odom(32'd0, 32'd0, 32'd0, 1'b1), 1'b1,
                   {1'b0, 32'd0, 32'd1, 32'd0});
        add_vector(make_odom(32'h7fff_ffff, 32'd0, 32'h7fff_ffff, 1'b1), 1'b0, none);
        add_vector(make_odom(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1), 1'b0, none);
        add_vector(make_odom(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b1), 1'b0, none);
        add_vector(make_odom(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b0), 1'b0, none);
        add_vector(make_odom(32'hffff_ffff, 32'h0001_0000, 32'h0000_0001, 1'b1), 1'b0, none);
        add_vector(make_odom(32'h0003_0000, 32'hfffe_0000, 32'h0000_0000, 1'b1), 1'b0, none);
        add_vector(make_odom(32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 1'b1), 1'b0, none);
        add_vector(make_odom(32'haaaa_aaaa, 32'h5555_5555, 32'hedcb_a987, 1'b0), 1'b0, none);
        foreach (vectors[i])
        begin
            send_word(vectors[i].word);
            if (vectors[i].has_fixed)
            begin
                accel_expected.pop_back();
                accel_expected.push_back(vectors[i].fixed);
            end
        end
        @(posedge clk);
        s_tvalid <= 1'b0;
        drain();

        // Extreme settings: zero rate and lateral limits; alpha above one, then zero.
        write_reg(ADDR_ALPHA, 32'h0001_ffff);
        write_reg(ADDR_PGXY, 32'h7fff_ffff);
        write_reg(ADDR_PGZ, 32'h7fff_ffff);
        write_reg(ADDR_VGXY, 32'h7fff_ffff);
        write_reg(ADDR_VGZ, 32'h7fff_ffff);
        write_reg(ADDR_DESCENT, 32'd0);
        write_reg(ADDR_ASCENT, 32'd0);
        write_reg(ADDR_LATERAL, 32'd0);
        vectors.delete();
        add_vector(make_odom(32'h0000_0001, 32'd0, 32'd0, 1'b1), 1'b0, none);
        add_vector(make_odom(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b1), 1'b0, none);
        add_vector(make_odom(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b1), 1'b0, none);
        add_vector(make_odom(32'd0, 32'd0, 32'd0, 1'b0), 1'b0, none);
        write_reg(ADDR_ALPHA, 32'd0);
        foreach (vectors[i])
            send_word(vectors[i].word);
        @(posedge clk);
        s_tvalid <= 1'b0;
        drain();
        write_reg(ADDR_DESCENT, 32'h0001_0000);
        write_reg(ADDR_ASCENT, 32'h7fff_ffff);
        write_reg(ADDR_LATERAL, 32'h7fff_ffff);
        for (int i = 0; i < 4; i++)
            send_word(random_odom());
        @(posedge clk);
        s_tvalid <= 1'b0;
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 80 : 0;
            recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 24 : 0;
            random_config();
            if (phase == 2)
                hold_off = 3000;
            for (int i = 0; i < N_RANDOM / 3; i++)
            begin
                if (i % 120 == 119)
                begin
                    @(posedge clk);
                    s_tvalid <= 1'b0;
                    drain();
                    random_config();
                end
                send_word(random_odom());
            end
            @(posedge clk);
            s_tvalid <= 1'b0;
            drain();
        end

        $display("Sent %0d odometry words over several gain settings, checked %0d results,",
                 words_sent, words_checked);
        $display("%0d of them with the tilt limit applied.", tilt_count);
        if (errors == 0 && accel_expected.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
